FILE: rtl/core/spt_pkg.sv
// Shared types and constants for the socket port table.
// Used by spt_front, spt_back and socket_port_table_unit; depends on nothing.
`timescale 1ns / 1ps
package spt_pkg;

   localparam int DEF_TABLE_ENTRIES = 16;
   localparam int DEF_MAX_PAYLOAD   = 2048;
   localparam logic [15:0] EPH_BASE = 16'd49152;
   localparam int EPH_TRIES         = 1000;
   localparam int TRIES_W           = 10;
   localparam int SLOT_W            = 8;

   typedef enum logic [2:0] {
      ACT_OPEN_UDP = 3'd0,
      ACT_OPEN_TCP = 3'd1,
      ACT_CLOSE    = 3'd2,
      ACT_DELIVER  = 3'd3,
      ACT_RECEIVE  = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      OP_OPEN_UDP,
      OP_OPEN_TCP,
      OP_CLOSE,
      OP_DELIVER,
      OP_RECEIVE,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_PORT_BUSY = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_BAD_HDL   = 3'd3,
      STAT_BAD_LEN   = 3'd4,
      STAT_NO_DATA   = 3'd5,
      STAT_NO_MATCH  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_RECV_RD,
      ST_RECV_EV,
      ST_DONE
   } state_type;

   // One classified word as it waits in the queue.
   typedef struct packed {
      op_type              op;
      logic                eph;
      logic                handle_ok;
      logic                len_ok;
      logic [SLOT_W-1:0]   slot;
      logic [15:0]         port;
      logic [31:0]         sip;
      logic [15:0]         sport;
      logic [15:0]         len;
   } item_type;

endpackage

FILE: rtl/core/socket_port_table_unit.sv
// Socket port table: UDP/TCP socket slots, port binding with ephemeral
// allocation, and a one-word mailbox per UDP socket.
//
// Request channel (req_*): one word per operation: open UDP, open TCP, close,
// deliver datagram, receive. A word is taken when req_valid is high and
// req_stall is low. A two-word queue sits behind the port, so requests are
// taken while the table is busy or a result waits.
// Result channel (rsp_*): one result word per request, in order, held in an
// output register until taken (rsp_valid high, rsp_stall low). A stalled
// result holds the sequencer; the queue then fills and raises req_stall.
// Sequence, from acceptance of a request to rsp_valid: the word is popped and
// dispatched; the table is scanned one entry at a time, each entry read and
// then evaluated. Close, rejected requests and unknown actions go from dispatch
// to the result; receive reads and evaluates the mailbox; open with a given port
// and deliver scan up to TABLE_ENTRIES entries. An ephemeral open scans the table
// for every candidate tried, at most 1000 candidates. The sequencer takes the next
// word in the cycle after a result is registered, so the table scan sets the rate.
// Reset (synchronous, active high) empties the table and the queue and sets
// the next ephemeral port to 49152; no clearing pass is needed.
// Depends on spt_pkg, spt_front and spt_back.
`timescale 1ns / 1ps
module socket_port_table_unit import spt_pkg::*; #(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int MAX_PAYLOAD   = DEF_MAX_PAYLOAD
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_port,
   input  logic [4:0]  req_handle,
   input  logic [31:0] req_source_ip,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_handle_out,
   output logic [15:0] rsp_port_out,
   output logic [31:0] rsp_ip_out,
   output logic [11:0] rsp_length_out,
   output logic [4:0]  rsp_open_count
);

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   spt_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .MAX_PAYLOAD  (MAX_PAYLOAD)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_port       (req_port),
      .req_handle     (req_handle),
      .req_source_ip  (req_source_ip),
      .req_source_port(req_source_port),
      .req_length     (req_length),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   spt_back #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_handle_out(rsp_handle_out),
      .rsp_port_out  (rsp_port_out),
      .rsp_ip_out    (rsp_ip_out),
      .rsp_length_out(rsp_length_out),
      .rsp_open_count(rsp_open_count)
   );

   // A failed operation returns no handle, address or length.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |->
         (rsp_handle_out == 5'd0 && rsp_ip_out == 32'd0 && rsp_length_out == 12'd0))
      else $error("failed result carries data");

   // An open result never carries mailbox contents.
   a_open_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_handle_out != 5'd0) |->
         (rsp_ip_out == 32'd0 && rsp_length_out == 12'd0))
      else $error("open result carries mailbox data");

   // The queue is never popped when empty.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   // The queue accepts again right after reset.
   a_reset_ready: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_stall)
      else $error("stall right after reset");

endmodule

FILE: rtl/core/spt_front.sv
// Front end: accepts request words, decodes and checks them, and queues them.
// Depends on spt_pkg.
`timescale 1ns / 1ps
module spt_front import spt_pkg::*; #(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int MAX_PAYLOAD   = DEF_MAX_PAYLOAD
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_port,
   input  logic [4:0]  req_handle,
   input  logic [31:0] req_source_ip,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_length,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type          cls;
   logic [8:0]        slot9;
   item_type          q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;

   always_comb begin
      cls       = '0;
      slot9     = {4'd0, req_handle} - 9'd1;
      unique case (req_action)
         ACT_OPEN_UDP: cls.op = OP_OPEN_UDP;
         ACT_OPEN_TCP: cls.op = OP_OPEN_TCP;
         ACT_CLOSE:    cls.op = OP_CLOSE;
         ACT_DELIVER:  cls.op = OP_DELIVER;
         ACT_RECEIVE:  cls.op = OP_RECEIVE;
         default:      cls.op = OP_NONE;
      endcase
      cls.eph       = (req_port == 16'd0);
      cls.handle_ok = (req_handle != 5'd0) &&
                      ({4'd0, req_handle} <= 9'(TABLE_ENTRIES));
      cls.len_ok    = ({1'b0, req_length} <= 17'(MAX_PAYLOAD));
      cls.slot      = slot9[SLOT_W-1:0];
      cls.port      = req_port;
      cls.sip       = req_source_ip;
      cls.sport     = req_source_port;
      cls.len       = req_length;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: rtl/core/spt_back.sv
// Back end: the socket table, its mailboxes, the sequencer that scans the table
// and the result register. Depends on spt_pkg.
`timescale 1ns / 1ps
module spt_back import spt_pkg::*; #(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_handle_out,
   output logic [15:0] rsp_port_out,
   output logic [31:0] rsp_ip_out,
   output logic [11:0] rsp_length_out,
   output logic [4:0]  rsp_open_count
);

   localparam int N     = TABLE_ENTRIES;
   localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
   localparam int CNT_W = $clog2(N + 1);

   state_type          state_ff, state_in;
   item_type           item_ff, item_in;
   logic [N-1:0]       used_ff, used_in, tcp_ff, tcp_in, ready_ff, ready_in;
   logic [15:0]        key_ff, key_in, eph_ff, eph_in, eph_next;
   logic [IDX_W-1:0]   idx_ff, idx_in, free_ff, free_in, slot, rd_addr, free_now;
   logic               found_ff, found_in;
   logic [TRIES_W-1:0] tries_ff, tries_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   status_type         status_ff, status_in;
   logic [4:0]         hout_ff, hout_in;
   logic [15:0]        pout_ff, pout_in;
   logic [31:0]        ipout_ff, ipout_in;
   logic [11:0]        lout_ff, lout_in;
   logic               rv_ff, rv_in;
   logic [2:0]         rs_ff, rs_in;
   logic [4:0]         rh_ff, rh_in, rc_ff, rc_in;
   logic [15:0]        rp_ff, rp_in;
   logic [31:0]        ri_ff, ri_in;
   logic [11:0]        rl_ff, rl_in;

   logic [15:0]        port_mem [N];
   logic [31:0]        mb_ip_mem [N];
   logic [15:0]        mb_port_mem [N];
   logic [15:0]        mb_len_mem [N];
   logic [15:0]        port_rd_ff, sport_rd_ff, mlen_rd_ff;
   logic [31:0]        ip_rd_ff;
   logic               port_we, mb_we;

   logic               is_del, is_open, ent_used, ent_tcp, hit, last, restart;
   logic               have_free, out_free, tries_done;
   logic [8:0]         h9, c9;
   logic [15:0]        clip;

   assign slot       = item_ff.slot[IDX_W-1:0];
   assign is_del     = (item_ff.op == OP_DELIVER);
   assign is_open    = (item_ff.op == OP_OPEN_UDP) || (item_ff.op == OP_OPEN_TCP);
   assign ent_used   = used_ff[idx_ff];
   assign ent_tcp    = tcp_ff[idx_ff];
   assign hit        = ent_used && (port_rd_ff == key_ff) && (!is_del || !ent_tcp);
   assign last       = (idx_ff == IDX_W'(N - 1));
   assign tries_done = (tries_ff == TRIES_W'(EPH_TRIES));
   assign restart    = hit && is_open && item_ff.eph && !tries_done;
   assign have_free  = found_ff || !ent_used;
   assign free_now   = found_ff ? free_ff : idx_ff;
   assign out_free   = !rv_ff || !rsp_stall;
   assign eph_next   = (eph_ff == 16'hFFFF) ? EPH_BASE : eph_ff + 16'd1;
   assign rd_addr    = (state_ff == ST_SCAN_RD) ? idx_ff : slot;
   assign h9         = 9'(free_now) + 9'd1;
   assign c9         = 9'(cnt_ff);
   assign clip       = (mlen_rd_ff > item_ff.len) ? item_ff.len : mlen_rd_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (item_ff.op)
               OP_OPEN_UDP, OP_OPEN_TCP: state_in = ST_SCAN_RD;
               OP_DELIVER: state_in = item_ff.len_ok ? ST_SCAN_RD : ST_DONE;
               OP_RECEIVE: begin
                  if (item_ff.handle_ok && used_ff[slot] && !tcp_ff[slot] &&
                      ready_ff[slot]) begin
                     state_in = ST_RECV_RD;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SCAN_RD: state_in = ST_SCAN_EV;
         ST_SCAN_EV: begin
            if (restart || (!hit && !last)) state_in = ST_SCAN_RD;
            else state_in = ST_DONE;
         end
         ST_RECV_RD: state_in = ST_RECV_EV;
         ST_RECV_EV: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and table updates.
   always_comb begin
      item_in   = item_ff;
      used_in   = used_ff;
      tcp_in    = tcp_ff;
      ready_in  = ready_ff;
      key_in    = key_ff;
      eph_in    = eph_ff;
      idx_in    = idx_ff;
      free_in   = free_ff;
      found_in  = found_ff;
      tries_in  = tries_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      hout_in   = hout_ff;
      pout_in   = pout_ff;
      ipout_in  = ipout_ff;
      lout_in   = lout_ff;
      rv_in     = rv_ff && rsp_stall;
      rs_in     = rs_ff;
      rh_in     = rh_ff;
      rp_in     = rp_ff;
      ri_in     = ri_ff;
      rl_in     = rl_ff;
      rc_in     = rc_ff;
      q_pop     = 1'b0;
      port_we   = 1'b0;
      mb_we     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
            end
         end
         ST_DISPATCH: begin
            status_in = STAT_OK;
            hout_in   = 5'd0;
            pout_in   = 16'd0;
            ipout_in  = 32'd0;
            lout_in   = 12'd0;
            idx_in    = '0;
            found_in  = 1'b0;
            key_in    = item_ff.port;
            case (item_ff.op)
               OP_OPEN_UDP, OP_OPEN_TCP: begin
                  if (item_ff.eph) begin
                     key_in   = eph_ff;
                     eph_in   = eph_next;
                     tries_in = TRIES_W'(1);
                  end
               end
               OP_DELIVER: begin
                  if (!item_ff.len_ok) status_in = STAT_BAD_LEN;
               end
               OP_CLOSE: begin
                  if (item_ff.handle_ok && used_ff[slot]) begin
                     used_in[slot]  = 1'b0;
                     ready_in[slot] = 1'b0;
                     cnt_in         = cnt_ff - CNT_W'(1);
                  end else begin
                     status_in = STAT_BAD_HDL;
                  end
               end
               OP_RECEIVE: begin
                  if (!item_ff.handle_ok || !used_ff[slot] || tcp_ff[slot]) begin
                     status_in = STAT_BAD_HDL;
                  end else if (!ready_ff[slot]) begin
                     status_in = STAT_NO_DATA;
                  end
               end
               default: status_in = STAT_OK;
            endcase
         end
         ST_SCAN_RD: begin
         end
         ST_SCAN_EV: begin
            if (!ent_used && !found_ff) begin
               free_in  = idx_ff;
               found_in = 1'b1;
            end
            idx_in = idx_ff + IDX_W'(1);
            if (hit) begin
               if (is_del) begin
                  mb_we            = 1'b1;
                  ready_in[idx_ff] = 1'b1;
                  status_in        = STAT_OK;
               end else if (restart) begin
                  // Candidate in use: take the next ephemeral port and rescan.
                  key_in   = eph_ff;
                  eph_in   = eph_next;
                  tries_in = tries_ff + TRIES_W'(1);
                  idx_in   = '0;
               end else begin
                  status_in = STAT_PORT_BUSY;
               end
            end else if (last) begin
               if (is_del) begin
                  status_in = STAT_NO_MATCH;
               end else if (have_free) begin
                  port_we            = 1'b1;
                  used_in[free_now]  = 1'b1;
                  tcp_in[free_now]   = (item_ff.op == OP_OPEN_TCP);
                  ready_in[free_now] = 1'b0;
                  cnt_in             = cnt_ff + CNT_W'(1);
                  hout_in            = h9[4:0];
                  pout_in            = key_ff;
               end else begin
                  status_in = STAT_FULL;
               end
            end
         end
         ST_RECV_RD: begin
         end
         ST_RECV_EV: begin
            ipout_in       = ip_rd_ff;
            pout_in        = sport_rd_ff;
            lout_in        = clip[11:0];
            ready_in[slot] = 1'b0;
         end
         ST_DONE: begin
            if (out_free) begin
               rv_in = 1'b1;
               rs_in = status_ff;
               rh_in = hout_ff;
               rp_in = pout_ff;
               ri_in = ipout_ff;
               rl_in = lout_ff;
               rc_in = c9[4:0];
            end
         end
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         tcp_ff   <= '0;
         ready_ff <= '0;
         eph_ff   <= EPH_BASE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         tcp_ff   <= tcp_in;
         ready_ff <= ready_in;
         eph_ff   <= eph_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      free_ff   <= free_in;
      found_ff  <= found_in;
      tries_ff  <= tries_in;
      status_ff <= status_in;
      hout_ff   <= hout_in;
      pout_ff   <= pout_in;
      ipout_ff  <= ipout_in;
      lout_ff   <= lout_in;
      rs_ff     <= rs_in;
      rh_ff     <= rh_in;
      rp_ff     <= rp_in;
      ri_ff     <= ri_in;
      rl_ff     <= rl_in;
      rc_ff     <= rc_in;
   end

   // Table memories: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (port_we) begin
         port_mem[free_now] <= key_ff;
      end
      port_rd_ff <= port_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mb_we) begin
         mb_ip_mem[idx_ff]   <= item_ff.sip;
         mb_port_mem[idx_ff] <= item_ff.sport;
         mb_len_mem[idx_ff]  <= item_ff.len;
      end
      ip_rd_ff    <= mb_ip_mem[rd_addr];
      sport_rd_ff <= mb_port_mem[rd_addr];
      mlen_rd_ff  <= mb_len_mem[rd_addr];
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = rs_ff;
   assign rsp_handle_out = rh_ff;
   assign rsp_port_out   = rp_ff;
   assign rsp_ip_out     = ri_ff;
   assign rsp_length_out = rl_ff;
   assign rsp_open_count = rc_ff;

endmodule
